/* rtl/gne_pkg.sv */
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types and constants of the 3D grid neighbour enumerator.
// ----------------------------------------------------------------------------
package gne_pkg;

    // Coordinate and grid size widths
    localparam int COORD_BITS  = 8;
    localparam int SIZE_BITS   = 8;
    // Width that holds a coordinate plus one and a size without overflow
    localparam int CMP_BITS    = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;

    // Offsets per axis (-1, 0, +1) and the whole 3x3x3 cube
    localparam int AXIS_OFFSETS = 3;
    localparam int NUM_OFFSETS  = AXIS_OFFSETS * AXIS_OFFSETS * AXIS_OFFSETS;

    // Job queue between classifier and sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // Register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_STYLE  = 2'd3
    } t_reg_idx;

    // Offset code along one axis
    typedef enum logic [1:0] {
        OFS_MINUS = 2'd0,
        OFS_ZERO  = 2'd1,
        OFS_PLUS  = 2'd2
    } t_ofs;

    // Input request
    typedef struct packed {
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
        logic [COORD_BITS-1:0] cell_z;
    } t_cell;

    // Result
    typedef struct packed {
        logic [COORD_BITS-1:0] nbr_x;
        logic [COORD_BITS-1:0] nbr_y;
        logic [COORD_BITS-1:0] nbr_z;
        logic                  found;
        logic                  last;
    } t_result;

    // Grid configuration
    typedef struct packed {
        logic [SIZE_BITS-1:0] size_x;
        logic [SIZE_BITS-1:0] size_y;
        logic [SIZE_BITS-1:0] size_z;
        logic                 style;
    } t_cfg;

    // Classified cell: which offsets survive
    typedef struct packed {
        t_cell                  coord;
        logic [NUM_OFFSETS-1:0] mask;
    } t_job;

endpackage

/* rtl/gne_front.sv */
// ----------------------------------------------------------------------------
// gne_front
// Classifies a cell: marks every offset of the 3x3x3 cube whose neighbour is
// kept by the neighbour style and lies inside the grid.
// ----------------------------------------------------------------------------
module gne_front (
    input  gne_pkg::t_cell i_cell,
    input  gne_pkg::t_cfg  i_cfg,
    output gne_pkg::t_job  o_job
);

    // Bounds check of c-1, c, c+1 against the axis size
    function automatic logic [gne_pkg::AXIS_OFFSETS-1:0] axis_ok(
        input logic [gne_pkg::COORD_BITS-1:0] c,
        input logic [gne_pkg::SIZE_BITS-1:0]  size
    );
        logic [gne_pkg::CMP_BITS-1:0] ce;
        logic [gne_pkg::CMP_BITS-1:0] se;
        logic [gne_pkg::AXIS_OFFSETS-1:0] ok;
        ce = gne_pkg::CMP_BITS'(c);
        se = gne_pkg::CMP_BITS'(size);
        ok[gne_pkg::OFS_MINUS] = (ce != '0) && ((ce - 1'b1) < se);
        ok[gne_pkg::OFS_ZERO]  = ce < se;
        ok[gne_pkg::OFS_PLUS]  = (ce + 1'b1) < se;
        return ok;
    endfunction

    logic [gne_pkg::AXIS_OFFSETS-1:0] w_ok_x;
    logic [gne_pkg::AXIS_OFFSETS-1:0] w_ok_y;
    logic [gne_pkg::AXIS_OFFSETS-1:0] w_ok_z;
    logic [gne_pkg::NUM_OFFSETS-1:0]  w_mask;

    assign w_ok_x = axis_ok(i_cell.cell_x, i_cfg.size_x);
    assign w_ok_y = axis_ok(i_cell.cell_y, i_cfg.size_y);
    assign w_ok_z = axis_ok(i_cell.cell_z, i_cfg.size_z);

    // Mark kept offsets; index = dx*9 + dy*3 + dz, x outermost
    always_comb begin
        int nz;
        w_mask = '0;
        for (int dx = 0; dx < gne_pkg::AXIS_OFFSETS; dx++) begin
            for (int dy = 0; dy < gne_pkg::AXIS_OFFSETS; dy++) begin
                for (int dz = 0; dz < gne_pkg::AXIS_OFFSETS; dz++) begin
                    nz = int'(dx != 1) + int'(dy != 1) + int'(dz != 1);
                    w_mask[(dx * gne_pkg::AXIS_OFFSETS + dy) * gne_pkg::AXIS_OFFSETS + dz] =
                        (nz != 0) && (i_cfg.style || (nz == 1))
                        && w_ok_x[dx] && w_ok_y[dy] && w_ok_z[dz];
                end
            end
        end
    end

    assign o_job.coord = i_cell;
    assign o_job.mask  = w_mask;

endmodule

/* rtl/gne_queue.sv */
// ----------------------------------------------------------------------------
// gne_queue
// Short FIFO of classified cells between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module gne_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gne_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output gne_pkg::t_job o_job,
    input  logic          i_pop
);

    gne_pkg::t_job                 r_mem [gne_pkg::QUEUE_DEPTH];
    logic [gne_pkg::QPTR_BITS-1:0] r_wptr;
    logic [gne_pkg::QPTR_BITS-1:0] r_rptr;
    logic [gne_pkg::QCNT_BITS-1:0] r_count;
    logic [gne_pkg::QPTR_BITS-1:0] n_wptr;
    logic [gne_pkg::QPTR_BITS-1:0] n_rptr;

    localparam logic [gne_pkg::QPTR_BITS-1:0] LAST_PTR =
        gne_pkg::QPTR_BITS'(gne_pkg::QUEUE_DEPTH - 1);
    localparam logic [gne_pkg::QCNT_BITS-1:0] FULL_CNT =
        gne_pkg::QCNT_BITS'(gne_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    // Wrap pointers at the depth
    assign n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/gne_back.sv */
// ----------------------------------------------------------------------------
// gne_back
// Sequencer: walks the offset mask of one cell, lowest offset first, and
// emits one neighbour per cycle through an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module gne_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  gne_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_res_valid,
    output gne_pkg::t_result o_res,
    input  logic             i_res_stall
);

    // Apply one offset code to a coordinate
    function automatic logic [gne_pkg::COORD_BITS-1:0] coord_step(
        input logic [gne_pkg::COORD_BITS-1:0] c,
        input gne_pkg::t_ofs                  ofs
    );
        logic [gne_pkg::COORD_BITS-1:0] r;
        case (ofs)
            gne_pkg::OFS_MINUS: r = c - 1'b1;
            gne_pkg::OFS_PLUS:  r = c + 1'b1;
            default:            r = c;
        endcase
        return r;
    endfunction

    logic                            r_busy;
    gne_pkg::t_cell                  r_cell;
    logic [gne_pkg::NUM_OFFSETS-1:0] r_mask;
    logic                            r_out_valid;
    gne_pkg::t_result                r_out;

    logic [gne_pkg::NUM_OFFSETS-1:0] w_sel_bit;
    logic [gne_pkg::NUM_OFFSETS-1:0] w_rest;
    gne_pkg::t_ofs                   w_ofs_x;
    gne_pkg::t_ofs                   w_ofs_y;
    gne_pkg::t_ofs                   w_ofs_z;
    logic                            w_hit;
    logic                            w_last;
    logic                            w_advance;
    gne_pkg::t_result                w_res;

    // Pick the lowest pending offset; descending scan so the lowest wins
    always_comb begin
        w_sel_bit = '0;
        w_hit     = 1'b0;
        w_ofs_x   = gne_pkg::OFS_ZERO;
        w_ofs_y   = gne_pkg::OFS_ZERO;
        w_ofs_z   = gne_pkg::OFS_ZERO;
        for (int dx = gne_pkg::AXIS_OFFSETS - 1; dx >= 0; dx--) begin
            for (int dy = gne_pkg::AXIS_OFFSETS - 1; dy >= 0; dy--) begin
                for (int dz = gne_pkg::AXIS_OFFSETS - 1; dz >= 0; dz--) begin
                    if (r_mask[(dx * gne_pkg::AXIS_OFFSETS + dy) * gne_pkg::AXIS_OFFSETS
                               + dz]) begin
                        w_sel_bit = '0;
                        w_sel_bit[(dx * gne_pkg::AXIS_OFFSETS + dy) * gne_pkg::AXIS_OFFSETS
                                  + dz] = 1'b1;
                        w_hit   = 1'b1;
                        w_ofs_x = gne_pkg::t_ofs'(2'(dx));
                        w_ofs_y = gne_pkg::t_ofs'(2'(dy));
                        w_ofs_z = gne_pkg::t_ofs'(2'(dz));
                    end
                end
            end
        end
    end

    assign w_rest = r_mask & ~w_sel_bit;
    assign w_last = (w_rest == '0);

    // Build the result; an empty mask gives the single no-neighbour result
    always_comb begin
        w_res.found = w_hit;
        w_res.last  = w_last;
        if (w_hit) begin
            w_res.nbr_x = coord_step(r_cell.cell_x, w_ofs_x);
            w_res.nbr_y = coord_step(r_cell.cell_y, w_ofs_y);
            w_res.nbr_z = coord_step(r_cell.cell_z, w_ofs_z);
        end else begin
            w_res.nbr_x = '0;
            w_res.nbr_y = '0;
            w_res.nbr_z = '0;
        end
    end

    // Emit when the output register is free or being drained
    assign w_advance = r_busy && (!r_out_valid || !i_res_stall);
    // Take the next cell when idle or on the final result of this one
    assign o_pop     = i_job_valid && (!r_busy || (w_advance && w_last));

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (w_advance && w_last) begin
            r_busy <= 1'b0;
        end
    end

    // Hold the cell and drop each offset as it is emitted
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cell <= i_job.coord;
            r_mask <= i_job.mask;
        end else if (w_advance) begin
            r_mask <= w_rest;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* rtl/grid_neighbour_enumerator_3d.sv */
// ----------------------------------------------------------------------------
// grid_neighbour_enumerator_3d
// Lists the in-bounds face (6) or full (26) neighbours of a 3D grid cell.
// ----------------------------------------------------------------------------
// Each request carries one cell; the block returns one result per neighbour
// inside the configured grid, ordered x offset outermost, then y, then z, each
// from -1 to +1, with last set on the final one. A cell with no neighbour in
// bounds gives a single result with found low, zero coordinates and last set.
// A request is classified in the cycle it is accepted and placed in a
// two-entry queue; the sequencer then emits one result per cycle while the
// output is not stalled, so a cell with n neighbours gives max(n, 1) results,
// and cells follow each other with no gap. Requests are accepted as long as
// the queue has room, also while results are still stalled. Grid size and
// neighbour style are written over the APB port at byte addresses 0, 4, 8 and
// 12 and must only change while no request is in flight.
// ----------------------------------------------------------------------------
module grid_neighbour_enumerator_3d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Cell requests
    input  logic                          i_cell_valid,
    input  gne_pkg::t_cell                i_cell,
    output logic                          o_cell_stall,
    // Neighbour results
    output logic                          o_res_valid,
    output gne_pkg::t_result              o_res,
    input  logic                          i_res_stall,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gne_pkg::ADDR_BITS-1:0] paddr,
    input  logic [gne_pkg::DATA_BITS-1:0] pwdata,
    output logic [gne_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [gne_pkg::SIZE_BITS-1:0] r_size_x;
    logic [gne_pkg::SIZE_BITS-1:0] r_size_y;
    logic [gne_pkg::SIZE_BITS-1:0] r_size_z;
    logic                          r_style;

    gne_pkg::t_cfg    w_cfg;
    gne_pkg::t_reg_idx w_reg;
    logic             w_cfg_wr;
    gne_pkg::t_job    w_front_job;
    gne_pkg::t_job    w_queue_job;
    logic             w_push;
    logic             w_full;
    logic             w_queue_valid;
    logic             w_pop;

    localparam logic [gne_pkg::SIZE_BITS-1:0] SIZE_RESET = gne_pkg::SIZE_BITS'(16);

    assign pready   = 1'b1;
    assign w_reg    = gne_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
            r_style  <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                gne_pkg::REG_SIZE_X: r_size_x <= pwdata[gne_pkg::SIZE_BITS-1:0];
                gne_pkg::REG_SIZE_Y: r_size_y <= pwdata[gne_pkg::SIZE_BITS-1:0];
                gne_pkg::REG_SIZE_Z: r_size_z <= pwdata[gne_pkg::SIZE_BITS-1:0];
                gne_pkg::REG_STYLE:  r_style  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (w_reg)
            gne_pkg::REG_SIZE_X: prdata = gne_pkg::DATA_BITS'(r_size_x);
            gne_pkg::REG_SIZE_Y: prdata = gne_pkg::DATA_BITS'(r_size_y);
            gne_pkg::REG_SIZE_Z: prdata = gne_pkg::DATA_BITS'(r_size_z);
            gne_pkg::REG_STYLE:  prdata = gne_pkg::DATA_BITS'(r_style);
            default:             prdata = '0;
        endcase
    end

    assign w_cfg.size_x = r_size_x;
    assign w_cfg.size_y = r_size_y;
    assign w_cfg.size_z = r_size_z;
    assign w_cfg.style  = r_style;

    // Accept a request while the queue has room
    assign o_cell_stall = w_full;
    assign w_push       = i_cell_valid && !w_full;

    gne_front u_front (
        .i_cell (i_cell),
        .i_cfg  (w_cfg),
        .o_job  (w_front_job)
    );

    gne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .o_valid (w_queue_valid),
        .o_job   (w_queue_job),
        .i_pop   (w_pop)
    );

    gne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_queue_valid),
        .i_job       (w_queue_job),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

/* rtl/gne_checker.sv */
// ----------------------------------------------------------------------------
// gne_checker
// Port-level checks of the neighbour enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module gne_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_res_valid,
    input  gne_pkg::t_result o_res,
    input  logic             i_res_stall
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    // The no-neighbour result closes its request
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.found |-> o_res.last)
        else $error("no-neighbour result without last");

    // The no-neighbour result carries zero coordinates
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.found |->
            (o_res.nbr_x == '0) && (o_res.nbr_y == '0) && (o_res.nbr_z == '0))
        else $error("no-neighbour result with coordinates");

    // Reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind grid_neighbour_enumerator_3d gne_checker u_gne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .o_res       (o_res),
    .i_res_stall (i_res_stall)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D grid neighbour enumerator.
// ----------------------------------------------------------------------------
// Cell requests are fed from a queue by a clocked driver; a clocked monitor
// compares every neighbour result with the list that the bench's own
// neighbour predictor built when the request was accepted. Grid sizes and
// neighbour style are reprogrammed over APB between drained phases: the reset
// grid, the largest grid, a one-cell grid, an empty axis and random grids.
// Both sides idle in random bursts, the receiver holds off once for a long
// stretch and the sender pauses once until all results are in.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES = 300;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Request and result channels
    logic             cell_valid  = 1'b0;
    gne_pkg::t_cell   cell_req    = '0;
    logic             o_cell_stall;
    logic             o_res_valid;
    gne_pkg::t_result o_res;
    logic             i_res_stall = 1'b0;

    // APB port
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [gne_pkg::ADDR_BITS-1:0] paddr   = '0;
    logic [gne_pkg::DATA_BITS-1:0] pwdata  = '0;
    logic [gne_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;

    grid_neighbour_enumerator_3d DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (cell_valid),
        .i_cell       (cell_req),
        .o_cell_stall (o_cell_stall),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .i_res_stall  (i_res_stall),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Bench state
    gne_pkg::t_cell   pending_cells[$];
    gne_pkg::t_result neighbour_results[$];
    gne_pkg::t_cfg    grid_cfg = '{size_x: 8'd16, size_y: 8'd16, size_z: 8'd16, style: 1'b0};
    gne_pkg::t_result want;
    bit      idle_enable    = 1'b1;
    int      hold_requests  = 0;
    int      holds_served   = 0;
    int      hold_left      = 0;
    int      stall_left     = 0;
    int      gap_left       = 0;
    int      errors         = 0;
    int      cells_accepted = 0;
    int      results_checked = 0;
    int      empty_results  = 0;
    int      settings_used  = 1;

    // Build the expected neighbour list of one cell under the current grid
    task automatic predict_neighbours(input gne_pkg::t_cell c);
        int               nx, ny, nz, moved;
        bit               have;
        gne_pkg::t_result prev;
        have = 1'b0;
        prev = '0;
        for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dz = -1; dz <= 1; dz++) begin
                    moved = (dx != 0) + (dy != 0) + (dz != 0);
                    if (moved == 0) continue;
                    if (!grid_cfg.style && moved != 1) continue;
                    nx = int'(c.cell_x) + dx;
                    ny = int'(c.cell_y) + dy;
                    nz = int'(c.cell_z) + dz;
                    if (nx < 0 || nx >= int'(grid_cfg.size_x)) continue;
                    if (ny < 0 || ny >= int'(grid_cfg.size_y)) continue;
                    if (nz < 0 || nz >= int'(grid_cfg.size_z)) continue;
                    if (have) neighbour_results.push_back(prev);
                    prev.nbr_x = nx[gne_pkg::COORD_BITS-1:0];
                    prev.nbr_y = ny[gne_pkg::COORD_BITS-1:0];
                    prev.nbr_z = nz[gne_pkg::COORD_BITS-1:0];
                    prev.found = 1'b1;
                    prev.last  = 1'b0;
                    have = 1'b1;
                end
            end
        end
        // No neighbour in bounds: one empty result
        if (!have) prev = '0;
        prev.last = 1'b1;
        neighbour_results.push_back(prev);
    endtask

    // Request driver: hold while stalled, idle in bursts, else offer the head
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (cell_valid && !o_cell_stall) begin
                predict_neighbours(cell_req);
                void'(pending_cells.pop_front());
                cells_accepted++;
            end
            if (!(cell_valid && o_cell_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cell_valid <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 8);
                    cell_valid <= 1'b0;
                end else if (pending_cells.size() != 0) begin
                    cell_valid <= 1'b1;
                    cell_req   <= pending_cells[0];
                end else begin
                    cell_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random bursts plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_res_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    // Result monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (neighbour_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_res);
                errors++;
            end else begin
                want = neighbour_results.pop_front();
                report_field("nbr_x", int'(want.nbr_x), int'(o_res.nbr_x));
                report_field("nbr_y", int'(want.nbr_y), int'(o_res.nbr_y));
                report_field("nbr_z", int'(want.nbr_z), int'(o_res.nbr_z));
                report_field("found", int'(want.found), int'(o_res.found));
                report_field("last",  int'(want.last),  int'(o_res.last));
                results_checked++;
                if (!want.found) empty_results++;
            end
        end
    end

    // One APB write: setup cycle, then access cycle
    task automatic write_reg(input gne_pkg::t_reg_idx idx,
                             input logic [gne_pkg::DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every request is taken and every result is in
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cells.size() != 0 || neighbour_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz, input bit full);
        wait_drained();
        write_reg(gne_pkg::REG_SIZE_X, gne_pkg::DATA_BITS'(sx));
        write_reg(gne_pkg::REG_SIZE_Y, gne_pkg::DATA_BITS'(sy));
        write_reg(gne_pkg::REG_SIZE_Z, gne_pkg::DATA_BITS'(sz));
        write_reg(gne_pkg::REG_STYLE,  gne_pkg::DATA_BITS'(full));
        grid_cfg.size_x = sx[gne_pkg::SIZE_BITS-1:0];
        grid_cfg.size_y = sy[gne_pkg::SIZE_BITS-1:0];
        grid_cfg.size_z = sz[gne_pkg::SIZE_BITS-1:0];
        grid_cfg.style  = full;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic add_cell(input int x, input int y, input int z);
        gne_pkg::t_cell c;
        c.cell_x = x[gne_pkg::COORD_BITS-1:0];
        c.cell_y = y[gne_pkg::COORD_BITS-1:0];
        c.cell_z = z[gne_pkg::COORD_BITS-1:0];
        pending_cells.push_back(c);
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 4);
            1:       return $urandom_range(5, 32);
            2:       return $urandom_range(33, 254);
            default: return 255;
        endcase
    endfunction

    // Often on a face of the grid or just past it, else inside it or anywhere in the field
    function automatic int pick_coord(input int size);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom_range(0, 255);
        if (r < 5) begin
            case ($urandom_range(0, 2))
                0:       return 0;
                1:       return size - 1;
                default: return size;
            endcase
        end
        return $urandom_range(0, size);
    endfunction

    task automatic add_random_cells(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) wait_drained();
            add_cell(pick_coord(grid_cfg.size_x), pick_coord(grid_cfg.size_y),
                     pick_coord(grid_cfg.size_z));
        end
    endtask

    // Stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset grid: corners, centre, just outside, far outside
        add_cell(0, 0, 0);
        add_cell(15, 15, 15);
        add_cell(5, 5, 5);
        add_cell(16, 5, 5);
        add_cell(254, 254, 254);
        add_cell(255, 0, 255);

        // Largest grid, all surrounding cells
        set_grid(255, 255, 255, 1'b1);
        add_cell(0, 0, 0);
        add_cell(100, 100, 100);
        add_cell(254, 254, 254);
        add_cell(255, 255, 255);
        add_cell(0, 254, 128);

        // One-cell grid: nothing around the only cell, one neighbour outside it
        set_grid(1, 1, 1, 1'b1);
        add_cell(0, 0, 0);
        add_cell(1, 0, 0);
        add_cell(1, 1, 1);

        // Flat grid with an empty axis: never any neighbour
        set_grid(8, 8, 0, 1'b0);
        add_cell(3, 3, 0);
        add_cell(0, 0, 255);

        // Small random grid, sender waits for everything midway
        set_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 1'b1);
        add_random_cells(50, 1'b1);

        // Largest grid with face style
        set_grid(255, 255, 255, 1'b0);
        add_random_cells(50, 1'b0);

        // Long result hold-off while requests keep coming
        set_grid(pick_size(), pick_size(), pick_size(), 1'b1);
        hold_requests <= hold_requests + 1;
        add_random_cells(50, 1'b0);

        for (int p = 0; p < 3; p++) begin
            set_grid(pick_size(), pick_size(), pick_size(), 1'($urandom_range(0, 1)));
            add_random_cells(50, 1'b0);
        end

        // Closing phase at full rate
        set_grid(pick_size(), pick_size(), pick_size(), 1'($urandom_range(0, 1)));
        idle_enable = 1'b0;
        add_random_cells(50, 1'b0);

        wait_drained();
        $display("Covered %0d cell requests over %0d grid settings, both neighbour styles.",
                 cells_accepted, settings_used);
        $display("Checked %0d neighbour results, %0d of them with no neighbour in bounds.",
                 results_checked, empty_results);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d requests and %0d results still waiting",
                 pending_cells.size(), neighbour_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
